// File: hw/rtl/neighbor_seqno_gap_tracker_top_defines.svh
// Assertion macros for the checker file ngt_checker.sv.
`ifndef NEIGHBOR_SEQNO_GAP_TRACKER_TOP_DEFINES_SVH
`define NEIGHBOR_SEQNO_GAP_TRACKER_TOP_DEFINES_SVH

// Checked at clk_i, off while rst_ni is low.
`define NGT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at clk_i, also during reset.
`define NGT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/ngt_pkg.sv
// Types and constants of the neighbor sequence-gap tracker.
package ngt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [3:0]  HDR_VERSION = 4'h1;
  localparam logic [15:0] AVG_UNITY   = 16'h0100;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_BAD_HDR = 2'd1,
    ST_OWN_ADDR = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0]  lqi;
    logic [7:0]  rssi;
    logic [7:0]  seq;
    logic [7:0]  header;
    logic [15:0] sender;
  } ngt_item_t;

  typedef struct packed {
    logic [15:0] avg;
    logic [7:0]  seq;
    logic [15:0] addr;
  } ngt_entry_t;

  localparam int ENTRY_W = $bits(ngt_entry_t);

  typedef struct packed {
    status_e     status;
    logic [5:0]  slot;
    logic        new_entry;
    logic [7:0]  gap;
    logic [15:0] avg;
    logic [15:0] ignored;
    logic [7:0]  rssi;
    logic [7:0]  lqi;
  } ngt_res_t;

endpackage

// File: hw/rtl/neighbor_seqno_gap_tracker_top.sv
// Top level of the neighbor sequence-gap tracker.
// Steps: header check, search over the used slots, update, then handoff of
// the result to the output register, which can stall on m_axis_tready.
// One beat at a time: the next input beat is taken only once the result of
// the last one is handed to the output register.
// Reset clears the fill count, ignored counter and handshake state at once.
module neighbor_seqno_gap_tracker_top import ngt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sender_address, header_byte, sequence_number, rssi_value, lqi_value
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // slot_index, new_entry, sequence_gap, average_gap, ignored_total,
  // link_rssi, link_lqi, one zero pad bit
  output logic [63:0] m_axis_tdata,
  // status
  output logic [1:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] own_addr_q;
  logic        m_valid_q;
  ngt_res_t    m_res_q;
  logic        res_valid;
  logic        res_ready;
  ngt_res_t    res;

  assign cfg_ready_o = 1'b1;
  assign res_ready   = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        own_addr_q <= cfg_data_i;
      end
      if (res_valid && res_ready) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_res_q <= res;
    end
  end

  ngt_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(s_axis_tvalid),
    .item_ready_o(s_axis_tready),
    .item_i      (ngt_item_t'(s_axis_tdata)),
    .own_addr_i  (own_addr_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_res_q.status;
  assign m_axis_tdata  = {1'b0, m_res_q.lqi, m_res_q.rssi, m_res_q.ignored, m_res_q.avg,
                          m_res_q.gap, m_res_q.new_entry, m_res_q.slot};

endmodule

// File: hw/rtl/ngt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ngt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/ngt_engine.sv
// Sequencer: header check, table search with one shared compare, average update.
module ngt_engine import ngt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      item_valid_i,
  output logic      item_ready_o,
  input  ngt_item_t item_i,
  input  logic [15:0] own_addr_i,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output ngt_res_t  res_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_SEARCH = 5'b00100,
    S_UPDATE = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  ngt_item_t        item_q, item_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] pend_idx_q, pend_idx_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic             new_q, new_d;
  logic [7:0]       last_q, last_d;
  logic [15:0]      avg_q, avg_d;
  logic [15:0]      ign_q, ign_d;
  ngt_res_t         res_q, res_d;

  logic             we;
  ngt_entry_t       wentry;
  logic [IDX_W-1:0] raddr;
  logic [ENTRY_W-1:0] rdata;
  ngt_entry_t       rentry;

  logic             bad_hdr;
  logic             hit;
  logic [7:0]       gap;
  logic [17:0]      avg_x3;
  logic [15:0]      avg_new;

  assign rentry  = ngt_entry_t'(rdata);
  assign bad_hdr = (item_q.header[7:4] != HDR_VERSION) || (item_q.header[3:0] == 4'h0);
  assign hit     = pend_q && (rentry.addr == item_q.sender);
  assign gap     = item_q.seq - last_q;
  assign avg_x3  = {2'b00, avg_q} + {1'b0, avg_q, 1'b0};
  assign avg_new = {2'b00, gap, 6'b0} + avg_x3[17:2];

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    scan_d     = scan_q;
    used_d     = used_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    slot_d     = slot_q;
    new_d      = new_q;
    last_d     = last_q;
    avg_d      = avg_q;
    ign_d      = ign_q;
    res_d      = res_q;
    we         = 1'b0;
    raddr      = scan_q[IDX_W-1:0];
    wentry     = '{avg: avg_new, seq: item_q.seq, addr: item_q.sender};

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_d  = item_i;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        res_d = '0;
        if (bad_hdr || (item_q.sender == own_addr_i)) begin
          ign_d          = ign_q + 16'd1;
          res_d.status   = bad_hdr ? ST_BAD_HDR : ST_OWN_ADDR;
          res_d.ignored  = ign_q + 16'd1;
          state_d        = S_DONE;
        end else begin
          scan_d  = '0;
          pend_d  = 1'b0;
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          slot_d  = pend_idx_q;
          new_d   = 1'b0;
          last_d  = rentry.seq;
          avg_d   = rentry.avg;
          pend_d  = 1'b0;
          state_d = S_UPDATE;
        end else if (scan_q < used_q) begin
          pend_d     = 1'b1;
          pend_idx_d = scan_q[IDX_W-1:0];
          scan_d     = scan_q + CNT_W'(1);
        end else begin
          pend_d = 1'b0;
          if (used_q >= CNT_W'(TABLE_DEPTH)) begin
            res_d         = '0;
            res_d.status  = ST_FULL;
            res_d.ignored = ign_q;
            state_d       = S_DONE;
          end else begin
            slot_d  = used_q[IDX_W-1:0];
            new_d   = 1'b1;
            last_d  = item_q.seq - 8'd1;
            avg_d   = AVG_UNITY;
            used_d  = used_q + CNT_W'(1);
            state_d = S_UPDATE;
          end
        end
      end
      S_UPDATE: begin
        we            = 1'b1;
        res_d.status  = ST_ACCEPT;
        res_d.slot    = 6'(slot_q);
        res_d.new_entry = new_q;
        res_d.gap     = gap;
        res_d.avg     = avg_new;
        res_d.ignored = ign_q;
        res_d.rssi    = item_q.rssi;
        res_d.lqi     = item_q.lqi;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      ign_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      ign_q   <= ign_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    scan_q     <= scan_d;
    pend_idx_q <= pend_idx_d;
    slot_q     <= slot_d;
    new_q      <= new_d;
    last_q     <= last_d;
    avg_q      <= avg_d;
    res_q      <= res_d;
  end

  ngt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(slot_q),
    .wdata_i(wentry),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign item_ready_o = (state_q == S_IDLE);
  assign res_valid_o  = (state_q == S_DONE);
  assign res_o        = res_q;

endmodule

// File: hw/rtl/ngt_checker.sv
// Port-level checks of the tracker, bound to the top level.
`include "neighbor_seqno_gap_tracker_top_defines.svh"

module ngt_checker import ngt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  `NGT_ASSERT(a_out_hold,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser), "output beat changed while stalled")
  `NGT_ASSERT(a_one_in_flight,
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while busy")
  `NGT_ASSERT(a_out_known,
    m_axis_tvalid |-> !$isunknown({m_axis_tuser, m_axis_tdata}), "unknown bits in result beat")
  `NGT_ASSERT(a_ignored_zero,
    m_axis_tvalid && (m_axis_tuser == ST_BAD_HDR || m_axis_tuser == ST_OWN_ADDR ||
    m_axis_tuser == ST_FULL) |-> m_axis_tdata[30:0] == 31'd0 &&
    m_axis_tdata[63:47] == 17'd0, "rejected beat carries link data")

endmodule

bind neighbor_seqno_gap_tracker_top ngt_checker u_ngt_checker (.*);
